>>> rtl/wma_pkg.sv
// shared types and constants for the windowed moving average block
package wma_pkg;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned TS_W      = 32;
  localparam int unsigned MAX_AGE_W = 16;
  localparam int unsigned WIN_W     = 5;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  // register index taken from paddr[2]
  localparam logic REG_MAX_AGE    = 1'b0;
  localparam logic REG_WINDOW_LEN = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_UPDATE = 2'd0,
    CMD_CHECK  = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SUM  = 6'b000010,
    S_ABS  = 6'b000100,
    S_DIV  = 6'b001000,
    S_FIX  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

endpackage

>>> rtl/windowed_moving_average_with_timeout_top.sv
// top level of the windowed moving average with data-age timeout
//
// Each input transfer carries a command in s_axis_tuser (update, time check or clear) and
// gives exactly one output transfer with the current average and the valid flag, after the
// command took effect. An update with window_len 0 passes the sample through; otherwise the
// sample is written into a ring store of DEPTH entries and the average is the mean of the
// newest fill_q entries, truncated toward zero; the fill count grows with each such update up
// to the window, is reset by a clear or a timed-out check and is kept when the window shrinks.
// The averaging update runs through one shared adder under a small sequencer: it reads and
// accumulates the stored samples (one ram read per cycle), takes the magnitude, runs a
// restoring division (one quotient bit per cycle), restores the sign and hands the result to
// the output register. A pass-through update, a time check or a clear goes straight to the
// hand-over. s_axis_tready is low while a command is in work. The output register lets a new
// command start while the previous result waits. The store needs no clearing after reset:
// only entries written since the last clear are ever read.
module windowed_moving_average_with_timeout_top
  import wma_pkg::*;
#(
  parameter int unsigned DEPTH        = 16,
  parameter int unsigned SAMPLE_WIDTH = 24,
  localparam int unsigned IN_DW  = ((SAMPLE_WIDTH + TS_W + 7) / 8) * 8,
  localparam int unsigned OUT_DW = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // command stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_DW-1:0]  s_axis_tdata,  // sample, timestamp, zero pad
  input  logic [CMD_W-1:0]  s_axis_tuser,  // command
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_DW-1:0] m_axis_tdata,  // average, zero pad
  output logic              m_axis_tuser,  // valid_res
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned SW  = SAMPLE_WIDTH;
  localparam int unsigned PW  = $clog2(DEPTH);      // store address
  localparam int unsigned CW  = $clog2(DEPTH + 1);  // fill count, holds DEPTH
  localparam int unsigned IW  = CW + 1;             // signed start index math
  localparam int unsigned AW  = SW + CW;            // exact sum and quotient register
  localparam int unsigned XW  = AW + 1;             // shared adder
  localparam int unsigned DCW = $clog2(AW + 1);     // divide step counter

  // payload fields
  logic [SW-1:0]   in_sample;
  logic [TS_W-1:0] in_ts;
  cmd_e            in_cmd;
  logic            in_xfer;
  logic            out_xfer;
  logic            cfg_wr;

  assign in_sample = s_axis_tdata[SW-1:0];
  assign in_ts     = s_axis_tdata[SW+TS_W-1:SW];
  assign in_cmd    = cmd_e'(s_axis_tuser);
  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign out_xfer  = m_axis_tvalid && m_axis_tready;
  assign cfg_wr    = psel && penable && pwrite && pready;

  // state
  state_e           state_q, state_d;
  logic [MAX_AGE_W-1:0] max_age_q, max_age_d;
  logic [WIN_W-1:0] win_len_q, win_len_d;
  logic [PW-1:0]    wp_q, wp_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic [SW-1:0]    avg_q, avg_d;
  logic             vset_q, vset_d;
  logic [TS_W-1:0]  last_q, last_d;

  // sequencer working registers
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    iss_q, iss_d;
  logic             rd_vld_q, rd_vld_d;
  logic [AW-1:0]    acc_q, acc_d;
  logic [CW-1:0]    rem_q, rem_d;
  logic             neg_q, neg_d;
  logic [DCW-1:0]   div_cnt_q, div_cnt_d;

  // output register
  logic             m_valid_q, m_valid_d;
  logic [SW-1:0]    m_avg_q, m_avg_d;
  logic             m_flag_q, m_flag_d;

  // store port
  logic             ram_we;
  logic             ram_re;
  logic [SW-1:0]    ram_rdata;

  wma_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (in_sample),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  // effective window, saturated at the store depth
  logic [CW-1:0] win_eff;
  assign win_eff = (32'(win_len_q) > DEPTH) ? CW'(DEPTH) : CW'(win_len_q);

  // ring bookkeeping for an averaging update
  logic [PW-1:0] wp_next;
  logic [CW-1:0] fill_new;
  logic [IW-1:0] start_diff;
  logic [IW-1:0] start_wrap;
  logic [PW-1:0] start_idx;
  assign wp_next    = (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
  assign fill_new   = (fill_q < win_eff) ? fill_q + CW'(1) : fill_q;
  assign start_diff = IW'(wp_next) - IW'(fill_new);
  assign start_wrap = start_diff + IW'(DEPTH);
  assign start_idx  = start_diff[IW-1] ? start_wrap[PW-1:0] : start_diff[PW-1:0];

  // data age, wrapping
  logic [TS_W-1:0] age;
  assign age = in_ts - last_q;

  // shared adder: accumulate, negate or trial subtract
  logic [XW-1:0] op_a;
  logic [XW-1:0] op_b;
  logic          op_cin;
  logic [XW-1:0] add_res;
  logic          trial_neg;

  always_comb begin
    op_a   = '0;
    op_b   = ~{acc_q[AW-1], acc_q};
    op_cin = 1'b1;
    case (state_q)
      S_SUM: begin
        op_a   = {acc_q[AW-1], acc_q};
        op_b   = {{(XW-SW){ram_rdata[SW-1]}}, ram_rdata};
        op_cin = 1'b0;
      end
      S_DIV: begin
        op_a   = XW'({rem_q, acc_q[AW-1]});
        op_b   = ~XW'(fill_q);
        op_cin = 1'b1;
      end
      default: begin
        op_a   = '0;
        op_b   = ~{acc_q[AW-1], acc_q};
        op_cin = 1'b1;
      end
    endcase
  end

  assign add_res   = op_a + op_b + XW'(op_cin);
  assign trial_neg = add_res[XW-1];

  // sequencer
  always_comb begin
    state_d   = state_q;
    max_age_d = max_age_q;
    win_len_d = win_len_q;
    wp_d      = wp_q;
    fill_d    = fill_q;
    avg_d     = avg_q;
    vset_d    = vset_q;
    last_d    = last_q;
    rd_ptr_d  = rd_ptr_q;
    iss_d     = iss_q;
    rd_vld_d  = 1'b0;
    acc_d     = acc_q;
    rem_d     = rem_q;
    neg_d     = neg_q;
    div_cnt_d = div_cnt_q;
    m_valid_d = m_valid_q;
    m_avg_d   = m_avg_q;
    m_flag_d  = m_flag_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;

    if (cfg_wr) begin
      case (paddr[2])
        REG_MAX_AGE:    max_age_d = pwdata[MAX_AGE_W-1:0];
        REG_WINDOW_LEN: win_len_d = pwdata[WIN_W-1:0];
        default: ;
      endcase
    end

    if (out_xfer) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_DONE;
          case (in_cmd)
            CMD_UPDATE: begin
              last_d = in_ts;
              vset_d = 1'b1;
              if (win_eff == '0) begin
                avg_d = in_sample;
              end else begin
                ram_we   = 1'b1;
                wp_d     = wp_next;
                fill_d   = fill_new;
                rd_ptr_d = start_idx;
                iss_d    = '0;
                acc_d    = '0;
                state_d  = S_SUM;
              end
            end
            CMD_CHECK: begin
              if ((max_age_q != '0) && (age > TS_W'(max_age_q))) begin
                vset_d = 1'b0;
                avg_d  = '0;
                wp_d   = '0;
                fill_d = '0;
              end
            end
            CMD_CLEAR: begin
              vset_d = 1'b0;
              avg_d  = '0;
              wp_d   = '0;
              fill_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_SUM: begin
        // one read issued per cycle, data summed the cycle after
        if (rd_vld_q) begin
          acc_d = add_res[AW-1:0];
        end
        if (iss_q != fill_q) begin
          ram_re   = 1'b1;
          rd_vld_d = 1'b1;
          iss_d    = iss_q + CW'(1);
          rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
        end else if (!rd_vld_q) begin
          state_d = S_ABS;
        end
      end
      S_ABS: begin
        neg_d     = acc_q[AW-1];
        if (acc_q[AW-1]) begin
          acc_d = add_res[AW-1:0];
        end
        rem_d     = '0;
        div_cnt_d = '0;
        state_d   = S_DIV;
      end
      S_DIV: begin
        // restoring divide, quotient bits shift in behind the dividend
        if (!trial_neg) begin
          rem_d = add_res[CW-1:0];
        end else begin
          rem_d = {rem_q[CW-2:0], acc_q[AW-1]};
        end
        acc_d     = {acc_q[AW-2:0], !trial_neg};
        div_cnt_d = div_cnt_q + DCW'(1);
        if (div_cnt_q == DCW'(AW - 1)) begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        avg_d   = neg_q ? add_res[SW-1:0] : acc_q[SW-1:0];
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_avg_d   = avg_q;
          m_flag_d  = vset_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      max_age_q <= '0;
      win_len_q <= '0;
      wp_q      <= '0;
      fill_q    <= '0;
      avg_q     <= '0;
      vset_q    <= 1'b0;
      last_q    <= '0;
      rd_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      max_age_q <= max_age_d;
      win_len_q <= win_len_d;
      wp_q      <= wp_d;
      fill_q    <= fill_d;
      avg_q     <= avg_d;
      vset_q    <= vset_d;
      last_q    <= last_d;
      rd_vld_q  <= rd_vld_d;
      m_valid_q <= m_valid_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    rd_ptr_q  <= rd_ptr_d;
    iss_q     <= iss_d;
    acc_q     <= acc_d;
    rem_q     <= rem_d;
    neg_q     <= neg_d;
    div_cnt_q <= div_cnt_d;
    m_avg_q   <= m_avg_d;
    m_flag_q  <= m_flag_d;
  end

  // ports
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_DW'(m_avg_q);
  assign m_axis_tuser  = m_flag_q;
  assign pready        = 1'b1;
  assign prdata        = (paddr[2] == REG_WINDOW_LEN) ? APB_DW'(win_len_q)
                                                      : APB_DW'(max_age_q);

  // fill count never passes the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(DEPTH))
    else $error("fill count beyond store depth");

  // partial remainder stays below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < fill_q))
    else $error("divide remainder out of range");

  // a result appears only when the sequencer hands it over
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == S_DONE))
    else $error("result without finished command");

  // an accepted command holds s_axis_tready low in the cycle after it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready)
    else $error("command accepted while busy");

endmodule

>>> rtl/wma_ram.sv
// generic single write port ram with registered read
module wma_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> bench/wma_average_checker.sv
// checker that predicts and compares the averaged results of the moving average block
module wma_average_checker
  import wma_pkg::*;
#(
  parameter int unsigned DEPTH        = 16,
  parameter int unsigned SAMPLE_WIDTH = 24,
  parameter int unsigned IN_DW        = 56,
  parameter int unsigned OUT_DW       = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  input  logic              s_axis_tready_i,
  input  logic [IN_DW-1:0]  s_axis_tdata_i,   // sample, timestamp, zero pad
  input  logic [CMD_W-1:0]  s_axis_tuser_i,   // command
  input  logic              m_axis_tvalid_i,
  input  logic              m_axis_tready_i,
  input  logic [OUT_DW-1:0] m_axis_tdata_i,   // average, zero pad
  input  logic              m_axis_tuser_i,   // valid_res
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [APB_AW-1:0] paddr_i,
  input  logic [APB_DW-1:0] pwdata_i,
  input  logic              pready_i,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] average;
    logic                    valid_res;
  } avg_result_t;

  logic signed [SAMPLE_WIDTH-1:0] ring [DEPTH];
  int unsigned                    wr_ptr;
  int unsigned                    fill;
  logic signed [SAMPLE_WIDTH-1:0] avg_now;
  logic                           have_value;
  logic [TS_W-1:0]                last_ts;
  logic [MAX_AGE_W-1:0]           max_age;
  logic [WIN_W-1:0]               window_len;
  avg_result_t                    avg_expect_q [$];
  int                             errs;

  assign fail_count_o = errs;

  task automatic clear_average();
    have_value = 1'b0;
    avg_now    = '0;
    wr_ptr     = 0;
    fill       = 0;
  endtask

  task automatic apply_command(input logic [CMD_W-1:0] code,
                               input logic signed [SAMPLE_WIDTH-1:0] smp,
                               input logic [TS_W-1:0] ts);
    int unsigned     win;
    int unsigned     idx;
    longint          acc;
    longint          quot;
    logic [TS_W-1:0] age;
    case (code)
      CMD_UPDATE: begin
        win = (window_len > DEPTH) ? DEPTH : window_len;
        if (win == 0) begin
          avg_now = smp;
        end else begin
          ring[wr_ptr] = smp;
          wr_ptr = (wr_ptr + 1) % DEPTH;
          if (fill < win) fill++;
          // mean of the newest fill entries, truncated toward zero
          idx = (wr_ptr + DEPTH - fill) % DEPTH;
          acc = 0;
          for (int k = 0; k < fill; k++) begin
            acc += ring[idx];
            idx = (idx + 1) % DEPTH;
          end
          quot    = acc / longint'(fill);
          avg_now = quot[SAMPLE_WIDTH-1:0];
        end
        last_ts    = ts;
        have_value = 1'b1;
      end
      CMD_CHECK: begin
        age = ts - last_ts;
        if (max_age != 0 && age > max_age) clear_average();
      end
      CMD_CLEAR: begin
        clear_average();
      end
      default: ;
    endcase
    avg_expect_q.push_back('{average: avg_now, valid_res: have_value});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    avg_result_t got;
    avg_result_t want;
    if (!rst_ni) begin
      clear_average();
      last_ts    = '0;
      max_age    = '0;
      window_len = '0;
      avg_expect_q.delete();
      errs       = 0;
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[2])
          REG_MAX_AGE:    max_age    = pwdata_i[MAX_AGE_W-1:0];
          REG_WINDOW_LEN: window_len = pwdata_i[WIN_W-1:0];
          default: ;
        endcase
      end
      // results first: a result can never belong to a command taken at the same edge
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = '{average: m_axis_tdata_i[SAMPLE_WIDTH-1:0], valid_res: m_axis_tuser_i};
        if (avg_expect_q.size() == 0) begin
          errs++;
          $error("unexpected result: average %0d valid_res %0b",
                 $signed(got.average), got.valid_res);
        end else begin
          want = avg_expect_q.pop_front();
          if (got.average !== want.average) begin
            errs++;
            $error("average: expected %0d, got %0d",
                   $signed(want.average), $signed(got.average));
          end
          if (got.valid_res !== want.valid_res) begin
            errs++;
            $error("valid_res: expected %0b, got %0b", want.valid_res, got.valid_res);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        apply_command(s_axis_tuser_i, s_axis_tdata_i[SAMPLE_WIDTH-1:0],
                      s_axis_tdata_i[SAMPLE_WIDTH +: TS_W]);
      end
      pending_o <= avg_expect_q.size();
    end
  end

endmodule

>>> bench/tb.sv
// testbench top: stimulus, configuration phases and verdict for the moving average block
module tb;
  import wma_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned SAMPLE_WIDTH = 24;
  localparam int unsigned IN_DW        = ((SAMPLE_WIDTH + TS_W + 7) / 8) * 8;
  localparam int unsigned OUT_DW       = ((SAMPLE_WIDTH + 7) / 8) * 8;
  // the run is 515 commands plus configuration writes and drains
  localparam int unsigned CYCLE_LIMIT  = 400000;
  // margin over a full 16-entry average
  localparam int unsigned SETTLE       = 60;
  localparam int unsigned NUM_PHASES   = 7;
  localparam int unsigned PHASE_ITEMS  = 70;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                s_axis_tvalid  = 1'b0;
  logic                s_axis_tready;
  logic [IN_DW-1:0]    s_axis_tdata   = '0;          // sample, timestamp, zero pad
  logic [CMD_W-1:0]    s_axis_tuser   = CMD_UPDATE;  // command
  logic                m_axis_tvalid;
  logic                m_axis_tready  = 1'b0;
  logic [OUT_DW-1:0]   m_axis_tdata;                 // average, zero pad
  logic                m_axis_tuser;                 // valid_res
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [APB_AW-1:0]   paddr          = '0;
  logic [APB_DW-1:0]   pwdata         = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  int                  fail_count;
  int                  pending;

  // quiet turns off idling on both sides for one whole phase
  bit                  quiet      = 1'b0;
  int                  stall_left = 0;

  // stimulus shaping only: running clock, last update time and current age limit
  logic [TS_W-1:0]      t_now;
  logic [TS_W-1:0]      t_upd;
  logic [MAX_AGE_W-1:0] age_limit;

  windowed_moving_average_with_timeout_top #(
    .DEPTH       (DEPTH),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  wma_average_checker #(
    .DEPTH       (DEPTH),
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .IN_DW       (IN_DW),
    .OUT_DW      (OUT_DW)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_i(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_i(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_i (m_axis_tdata),
    .m_axis_tuser_i (m_axis_tuser),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .pready_i       (pready),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side backpressure: mostly short stalls, now and then a long one that
  // outlasts the next command and so pushes back into s_axis_tready
  always @(posedge clk_i) begin
    int r;
    r = $urandom_range(999);
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && r < 4) begin
      stall_left    <= $urandom_range(11);
      m_axis_tready <= 1'b0;
    end else if (!quiet && r < 5) begin
      stall_left    <= $urandom_range(59, 20);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  // register write: setup cycle, then access cycle until pready
  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [MAX_AGE_W-1:0] age, input logic [WIN_W-1:0] win);
    apb_write({REG_MAX_AGE, 2'b00}, APB_DW'(age));
    apb_write({REG_WINDOW_LEN, 2'b00}, APB_DW'(win));
    age_limit = age;
  endtask

  // one command transfer; tvalid stays high into the next command unless a gap is taken,
  // so it never gets two assignments in one step
  task automatic send_command(input cmd_e code, input logic [SAMPLE_WIDTH-1:0] smp,
                              input logic [TS_W-1:0] ts);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(99) < 10) gap = $urandom_range(40, 1);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= code;
    s_axis_tdata  <= IN_DW'({ts, smp});
    do @(posedge clk_i); while (!s_axis_tready);
    if (code == CMD_UPDATE) t_upd = ts;
  endtask

  // let every outstanding result come out, then hold off a little
  task automatic drain(input int unsigned settle);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (settle) @(posedge clk_i);
  endtask

  // mostly updates so the window fills up; time checks cluster around the age threshold
  task automatic random_item();
    int                      r;
    cmd_e                    code;
    logic [SAMPLE_WIDTH-1:0] smp;
    logic [TS_W-1:0]         ts;
    r    = $urandom_range(99);
    code = (r < 72) ? CMD_UPDATE : (r < 95) ? CMD_CHECK : CMD_CLEAR;
    case ($urandom_range(9))
      0:       smp = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      1:       smp = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      2:       smp = SAMPLE_WIDTH'($urandom_range(511)) - SAMPLE_WIDTH'(256);
      default: smp = SAMPLE_WIDTH'($urandom);
    endcase
    if (code == CMD_UPDATE) begin
      if ($urandom_range(19) == 0) begin
        ts = $urandom;
      end else begin
        t_now = t_now + $urandom_range(3 * age_limit + 10);
        ts    = t_now;
      end
    end else begin
      r = $urandom_range(9);
      if (r < 2)      ts = $urandom;
      else if (r < 6) ts = t_upd + age_limit + $urandom_range(3) - 1;
      else            ts = t_upd + $urandom_range(age_limit);
    end
    send_command(code, smp, ts);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni   <= 1'b1;
    t_now     = $urandom;
    t_upd     = '0;
    age_limit = '0;

    // pass-through with a short age limit
    set_config(16'd100, 5'd0);
    send_command(CMD_CHECK,  24'h000000, 32'd100);        // age measured from time zero, kept
    send_command(CMD_CHECK,  24'h000000, 32'd101);        // just over the limit
    send_command(CMD_UPDATE, 24'h7FFFFF, 32'd5);
    send_command(CMD_UPDATE, 24'h800000, 32'd6);
    send_command(CMD_CHECK,  24'hFFFFFF, 32'd106);        // age equal to limit, kept
    send_command(CMD_CHECK,  24'hFFFFFF, 32'd107);        // clears
    send_command(CMD_UPDATE, 24'h000180, 32'hFFFF_FFF0);
    send_command(CMD_CHECK,  24'h000000, 32'h0000_0054);  // age across the wrap, kept
    send_command(CMD_CHECK,  24'h000000, 32'h0000_0055);  // clears
    send_command(CMD_UPDATE, 24'h000001, 32'hFFFF_FFFF);
    send_command(CMD_CLEAR,  24'h000000, 32'h0000_0000);
    drain(4);

    // window of 3: negative means truncate toward zero, the window slides along the ring
    set_config(16'hFFFF, 5'd3);
    send_command(CMD_UPDATE, 24'hFFFFFD, 32'h1000);
    send_command(CMD_UPDATE, 24'h000001, 32'h1001);
    send_command(CMD_UPDATE, 24'h000001, 32'h1002);
    send_command(CMD_UPDATE, 24'hFFFFFE, 32'h1003);
    send_command(CMD_UPDATE, 24'h7FFFFF, 32'h1004);
    drain(4);

    // window shrunk while filled keeps the old fill; age check off
    set_config(16'd0, 5'd2);
    send_command(CMD_UPDATE, 24'h000004, 32'h1005);
    send_command(CMD_CHECK,  24'h000000, 32'hFFFF_FFFF);
    send_command(CMD_CLEAR,  24'h000000, 32'h0000_0000);
    send_command(CMD_UPDATE, 24'h800000, 32'h1006);
    drain(4);

    // full window and the largest age limit
    set_config(16'hFFFF, 5'd16);
    send_command(CMD_UPDATE, 24'h800000, 32'h2000);
    send_command(CMD_UPDATE, 24'h800000, 32'h2001);
    send_command(CMD_CHECK,  24'h000000, t_upd + 32'd65535);
    send_command(CMD_CHECK,  24'h000000, t_upd + 32'd65536);
    send_command(CMD_UPDATE, 24'h7FFFFF, 32'h3000);
    drain(4);

    // random phases; no clear between them so a window change meets a filled ring
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       set_config(16'd0, 5'd16);
        1:       set_config(16'hFFFF, 5'd16);
        2:       set_config(16'd1000, 5'd5);
        3:       set_config(16'd1, 5'd1);
        4:       set_config(MAX_AGE_W'($urandom_range(65535, 1)), 5'd0);
        5:       set_config(16'd50, 5'd12);
        default: set_config(MAX_AGE_W'($urandom), WIN_W'($urandom_range(16)));
      endcase
      quiet = (ph == 1);
      repeat (PHASE_ITEMS) random_item();
      drain(4);
      quiet = 1'b0;
    end

    drain(SETTLE);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/wma_pkg.sv
rtl/wma_ram.sv
rtl/windowed_moving_average_with_timeout_top.sv
bench/wma_average_checker.sv
bench/tb.sv
